[hdl/ipc_pkg.sv]
`timescale 1ns / 1ps

package ipc_pkg;

  // Number of lamps: bit0 green, bit1 yellow, bit2 blue, bit3 red
  localparam int unsigned NUM_LAMPS = 4;

  // Target bytes
  localparam logic [7:0] TGT_GREEN  = 8'h47;  // 'G'
  localparam logic [7:0] TGT_YELLOW = 8'h59;  // 'Y'
  localparam logic [7:0] TGT_BLUE   = 8'h42;  // 'B'
  localparam logic [7:0] TGT_RED    = 8'h52;  // 'R'
  localparam logic [7:0] TGT_ALL_A  = 8'hFF;
  localparam logic [7:0] TGT_ALL_B  = 8'hFE;

  // Mode bytes
  localparam logic [7:0] MB_BLINK  = 8'h42;  // 'B'
  localparam logic [7:0] MB_FLASH  = 8'h46;  // 'F'
  localparam logic [7:0] MB_DOUBLE = 8'h44;  // 'D'
  localparam logic [7:0] MB_SOLID  = 8'h53;  // 'S'
  localparam logic [7:0] MB_OFF    = 8'h4F;  // 'O'

  localparam logic [2:0] BLINK_PERIOD_RESET = 3'd5;

  typedef enum logic [2:0] {
    MODE_NONE   = 3'd0,
    MODE_BLINK  = 3'd1,
    MODE_FLASH  = 3'd2,
    MODE_DOUBLE = 3'd3,
    MODE_SOLID  = 3'd4,
    MODE_OFF    = 3'd5
  } mode_t;

  // One result beat
  typedef struct packed {
    logic [NUM_LAMPS-1:0] lamp_levels;
    logic [NUM_LAMPS-1:0] pulse_lamps;
    logic                 check_request;
  } res_t;

  function automatic mode_t decode_mode(input logic [7:0] mb);
    mode_t m;
    case (mb)
      MB_BLINK:  m = MODE_BLINK;
      MB_FLASH:  m = MODE_FLASH;
      MB_DOUBLE: m = MODE_DOUBLE;
      MB_SOLID:  m = MODE_SOLID;
      MB_OFF:    m = MODE_OFF;
      default:   m = MODE_NONE;
    endcase
    return m;
  endfunction

endpackage

[hdl/indicator_pattern_controller.sv]
`timescale 1ns / 1ps

// Channel | Handshake          | Payload
// --------+--------------------+-------------------------------------------
// in      | in_valid/in_stall  | cmd_valid, cmd_target, cmd_mode, tick
// out     | out_valid/out_stall| lamp_levels, pulse_lamps, check_request
// cfg     | cfg_wr_en          | cfg_wr_data (blink_period_ticks)
//
// The pass is computed from the input beat and the lamp state in one stage
// and written into the output register (or the skid register) at acceptance.
// Throughput is one beat per cycle while in_stall is low.
// A skid register behind the output register takes one more beat while the
// output is stalled; in_stall is high only when that skid entry is full.
// rst (synchronous) clears modes to none, pins, tick counter and the
// blink/flash done flags, sets the period to 5 and empties both registers.

module indicator_pattern_controller (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  // input beat
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cmd_valid,
  input  logic [7:0] cmd_target,
  input  logic [7:0] cmd_mode,
  input  logic       tick,
  // result beat
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] lamp_levels,
  output logic [3:0] pulse_lamps,
  output logic       check_request
);

  localparam int unsigned NL = ipc_pkg::NUM_LAMPS;

  // state
  logic [2:0]           blink_period_ticks;
  ipc_pkg::mode_t       lamp_modes [NL];
  logic [NL-1:0]        lamp_pins;
  logic [2:0]           tick_count;
  logic                 blink_done;
  logic                 flash_done;

  // output side
  ipc_pkg::res_t        out_res;
  ipc_pkg::res_t        skid_res;
  logic                 skid_valid;

  // pass results
  ipc_pkg::mode_t       lamp_modes_next [NL];
  logic [NL-1:0]        lamp_pins_next;
  logic [2:0]           tick_count_next;
  logic                 blink_armed;
  logic                 flash_armed;
  logic [NL-1:0]        pulses;
  logic                 check;
  ipc_pkg::res_t        pass_res;

  logic                 accept;
  logic                 out_take;
  logic [2:0]           tick_inc;
  logic                 all_sel;
  logic [NL-1:0]        lamp_sel;
  ipc_pkg::mode_t       new_mode;

  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign in_stall = skid_valid;

  // command decode
  always_comb begin
    new_mode    = ipc_pkg::decode_mode(cmd_mode);
    all_sel     = cmd_target inside {ipc_pkg::TGT_ALL_A, ipc_pkg::TGT_ALL_B};
    lamp_sel[0] = cmd_valid && (all_sel || cmd_target == ipc_pkg::TGT_GREEN);
    lamp_sel[1] = cmd_valid && (all_sel || cmd_target == ipc_pkg::TGT_YELLOW);
    lamp_sel[2] = cmd_valid && (all_sel || cmd_target == ipc_pkg::TGT_BLUE);
    lamp_sel[3] = cmd_valid && (all_sel || cmd_target == ipc_pkg::TGT_RED);
    for (int i = 0; i < NL; i++) begin
      lamp_modes_next[i] = lamp_sel[i] ? new_mode : lamp_modes[i];
    end
  end

  // tick counter; the period end re-arms blink, every tick re-arms flash
  always_comb begin
    tick_inc        = tick_count + 3'd1;
    tick_count_next = tick_count;
    blink_armed     = !blink_done;
    flash_armed     = !flash_done;
    if (tick) begin
      flash_armed = 1'b1;
      if (tick_inc == blink_period_ticks) begin
        tick_count_next = 3'd0;
        blink_armed     = 1'b1;
      end else begin
        tick_count_next = tick_inc;
      end
    end
  end

  // lamp service, each lamp on its own
  always_comb begin
    lamp_pins_next = lamp_pins;
    pulses         = '0;
    check          = 1'b0;
    for (int i = 0; i < NL; i++) begin
      case (lamp_modes_next[i])
        ipc_pkg::MODE_BLINK: begin
          if (blink_armed && tick_count_next == 3'd0) begin
            lamp_pins_next[i] = ~lamp_pins[i];
            check             = 1'b1;
          end
        end
        ipc_pkg::MODE_FLASH: begin
          if (flash_armed) begin
            lamp_pins_next[i] = ~lamp_pins[i];
            check             = 1'b1;
          end
        end
        ipc_pkg::MODE_DOUBLE: begin
          if (flash_armed) begin
            pulses[i] = 1'b1;
            check     = 1'b1;
          end
        end
        ipc_pkg::MODE_SOLID: begin
          lamp_pins_next[i] = 1'b1;
          check             = 1'b1;
        end
        ipc_pkg::MODE_OFF: begin
          lamp_pins_next[i] = 1'b0;
        end
        default: begin
        end
      endcase
    end
    pass_res.lamp_levels   = lamp_pins_next;
    pass_res.pulse_lamps   = pulses;
    pass_res.check_request = check;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_period_ticks <= ipc_pkg::BLINK_PERIOD_RESET;
    end else if (cfg_wr_en) begin
      blink_period_ticks <= cfg_wr_data;
    end
  end

  // lamp state, updated once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NL; i++) begin
        lamp_modes[i] <= ipc_pkg::MODE_NONE;
      end
      lamp_pins  <= '0;
      tick_count <= 3'd0;
      blink_done <= 1'b0;
      flash_done <= 1'b0;
    end else if (accept) begin
      lamp_modes <= lamp_modes_next;
      lamp_pins  <= lamp_pins_next;
      tick_count <= tick_count_next;
      blink_done <= 1'b1;
      flash_done <= 1'b1;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (accept) begin
        out_res   <= pass_res;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept) begin
      skid_res   <= pass_res;
      skid_valid <= 1'b1;
    end
  end

  assign lamp_levels   = out_res.lamp_levels;
  assign pulse_lamps   = out_res.pulse_lamps;
  assign check_request = out_res.check_request;

  // skid entry only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full with output register empty");

  // a stalled result is never dropped
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result lost");

  // a pulse always raises a check request
  a_pulse_check: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pulse_lamps != '0) |-> check_request)
    else $error("pulse without check request");

  // after a tick the counter never rests on a nonzero period
  a_tick_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && tick && !cfg_wr_en) |=>
      (tick_count != blink_period_ticks || blink_period_ticks == 3'd0))
    else $error("tick counter missed the period end");

endmodule
